### rtl/core/uud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uud_pkg
// Shared types, character codes and helpers of the uudecode character stream.
// ---------------------------------------------------------------------------
package uud_pkg;

    localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_BACKTICK = 8'd96;
    localparam logic [7:0] SEXTET_MASK   = 8'd63;
    localparam logic [6:0] COLUMN_MAX    = 7'd127;

    localparam int GROUP_DEPTH = 4;
    localparam int GROUP_PTR_W = $clog2(GROUP_DEPTH);
    localparam int GROUP_CNT_W = $clog2(GROUP_DEPTH + 1);

    // One decoded group of up to three bytes, first byte in the high bits.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nb;
        logic        line_end;
    } t_group;

    function automatic logic [5:0] to_sextet(input logic [7:0] c);
        logic [7:0] v;
        v = (c == CHAR_BACKTICK) ? CHAR_SPACE : c;
        return 6'((v - CHAR_SPACE) & SEXTET_MASK);
    endfunction

    function automatic logic [7:0] begin_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "b";
            3'd1:    ch = "e";
            3'd2:    ch = "g";
            3'd3:    ch = "i";
            3'd4:    ch = "n";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] end_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = "e";
            2'd1:    ch = "n";
            2'd2:    ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

### rtl/core/uud_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uud_front
// Line parser: tracks column, count and marker lines, gathers sextets and
// hands each completed group to the group queue.
// ---------------------------------------------------------------------------
module uud_front
    import uud_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    output logic            o_push,
    output t_group          o_group
);

    logic [6:0]  r_column,     n_column;
    logic [5:0]  r_line_count, n_line_count;
    logic [5:0]  r_bytes_done, n_bytes_done;
    logic [17:0] r_accum,      n_accum;
    logic [1:0]  r_index,      n_index;
    logic        r_begin,      n_begin;
    logic        r_end,        n_end;
    logic        r_skip,       n_skip;

    logic [5:0] sextet;
    logic [5:0] remain;
    logic [1:0] nb;
    logic       begin_hit;
    logic       end_hit;
    logic       stop;

    assign sextet = to_sextet(i_char);
    assign remain = r_line_count - r_bytes_done;
    assign nb     = (remain < 6'd3) ? remain[1:0] : 2'd3;

    always_comb begin
        n_column     = r_column;
        n_line_count = r_line_count;
        n_bytes_done = r_bytes_done;
        n_accum      = r_accum;
        n_index      = r_index;
        n_begin      = r_begin;
        n_end        = r_end;
        n_skip       = r_skip;
        begin_hit    = 1'b0;
        end_hit      = 1'b0;
        stop         = 1'b0;
        o_push       = 1'b0;
        o_group      = '0;
        if (i_accept) begin
            if (i_char == CHAR_NEWLINE) begin
                n_column     = '0;
                n_line_count = '0;
                n_bytes_done = '0;
                n_accum      = '0;
                n_index      = '0;
                n_begin      = 1'b0;
                n_end        = 1'b0;
                n_skip       = 1'b0;
            end else begin
                if (r_column != COLUMN_MAX) begin
                    n_column = r_column + 7'd1;
                end
                if (r_column == 7'd0) begin
                    n_line_count = sextet;
                    n_bytes_done = '0;
                    n_accum      = '0;
                    n_index      = '0;
                    n_begin      = (i_char == begin_char(3'd0));
                    n_end        = (i_char == end_char(2'd0));
                    n_skip       = (sextet == 6'd0);
                end else if (!r_skip) begin
                    if (r_column <= 7'd4) begin
                        begin_hit = r_begin && (i_char == begin_char(r_column[2:0]));
                        n_begin   = begin_hit;
                        if (r_column == 7'd4 && begin_hit) begin
                            n_skip = 1'b1;
                            stop   = 1'b1;
                        end
                    end
                    if (!stop && r_column <= 7'd2) begin
                        end_hit = r_end && (i_char == end_char(r_column[1:0]));
                        n_end   = end_hit;
                        if (r_column == 7'd2 && end_hit) begin
                            n_skip = 1'b1;
                            stop   = 1'b1;
                        end
                    end
                    if (!stop && r_bytes_done < r_line_count) begin
                        if (r_index != 2'd3) begin
                            n_accum = {r_accum[11:0], sextet};
                            n_index = r_index + 2'd1;
                        end else begin
                            o_push           = 1'b1;
                            o_group.word     = {r_accum, sextet};
                            o_group.nb       = nb;
                            o_group.line_end = (remain <= 6'd3);
                            n_bytes_done     = r_bytes_done + {4'b0, nb};
                            n_accum          = '0;
                            n_index          = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_line_count <= '0;
            r_bytes_done <= '0;
            r_accum      <= '0;
            r_index      <= '0;
            r_begin      <= 1'b0;
            r_end        <= 1'b0;
            r_skip       <= 1'b0;
        end else begin
            r_column     <= n_column;
            r_line_count <= n_line_count;
            r_bytes_done <= n_bytes_done;
            r_accum      <= n_accum;
            r_index      <= n_index;
            r_begin      <= n_begin;
            r_end        <= n_end;
            r_skip       <= n_skip;
        end
    end

endmodule
`default_nettype wire

### rtl/core/uud_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uud_fifo
// Short queue of decoded groups between the parser and the byte emitter.
// ---------------------------------------------------------------------------
module uud_fifo
    import uud_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_group,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_group      o_group
);

    t_group                  r_mem [GROUP_DEPTH];
    logic [GROUP_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [GROUP_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [GROUP_CNT_W-1:0]  r_count,  n_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_full   = (r_count == GROUP_CNT_W'(GROUP_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_group  = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;
    assign n_wr_ptr = do_push ? r_wr_ptr + GROUP_PTR_W'(1) : r_wr_ptr;
    assign n_rd_ptr = do_pop ? r_rd_ptr + GROUP_PTR_W'(1) : r_rd_ptr;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + GROUP_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - GROUP_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/core/uud_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uud_back
// Byte emitter: splits the head group into bytes, one per cycle while the
// output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module uud_back
    import uud_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_grp_valid,
    input  wire t_group     i_group,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last_of_run,
    output logic            o_out_last_of_line
);

    logic [1:0] r_k, n_k;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run;
    logic       r_line;
    logic       advance;
    logic       emit;
    logic       last;
    logic [7:0] sel_byte;

    assign advance = !r_valid || i_out_ready;
    assign emit    = advance && i_grp_valid;
    assign last    = (r_k == i_group.nb - 2'd1);
    assign o_pop   = emit && last;
    assign n_k     = emit ? (last ? 2'd0 : r_k + 2'd1) : r_k;

    always_comb begin
        unique case (r_k)
            2'd0:    sel_byte = i_group.word[23:16];
            2'd1:    sel_byte = i_group.word[15:8];
            default: sel_byte = i_group.word[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= sel_byte;
            r_run  <= last;
            r_line <= last && i_group.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (advance) begin
                r_valid <= i_grp_valid;
            end
            r_k <= n_k;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_out_byte         = r_byte;
    assign o_out_last_of_run  = r_run;
    assign o_out_last_of_line = r_line;

endmodule
`default_nettype wire

### rtl/core/uudecode_char_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uudecode_char_stream
// Streaming uudecoder: characters in, decoded bytes out.
// ---------------------------------------------------------------------------
// One character is accepted per cycle while the group queue has room; the
// parser works in the cycle of acceptance. Each fourth data character yields
// one group of up to three bytes, which the emitter sends one byte per cycle
// while the output is not stalled, through a registered output: a group is
// written to the queue, and each of its bytes then to the output register.
// Sustained input rate is one character per cycle, limited only by output
// back-pressure filling the four-group queue. No clearing pass follows reset.
// ---------------------------------------------------------------------------
module uudecode_char_stream
    import uud_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_char,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last_of_run,
    output logic            o_out_last_of_line
);

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   grp_valid;
    t_group grp_in;
    t_group grp_head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    uud_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in_char),
        .o_push   (push),
        .o_group  (grp_in)
    );

    uud_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (grp_in),
        .i_pop    (pop),
        .o_full   (full),
        .o_valid  (grp_valid),
        .o_group  (grp_head)
    );

    uud_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_grp_valid        (grp_valid),
        .i_group            (grp_head),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_out_last_of_run  (o_out_last_of_run),
        .o_out_last_of_line (o_out_last_of_line)
    );

endmodule
`default_nettype wire

### rtl/core/uud_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uud_checker
// Port-level checks of the uudecode character stream.
// ---------------------------------------------------------------------------
module uud_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [7:0] i_in_char,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_last_of_run,
    input wire logic       o_out_last_of_line
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("output item dropped or changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_char))
        else $error("input item dropped or changed while stalled");

    a_line_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last_of_line |-> o_out_last_of_run)
        else $error("line end marked inside a group");

    a_group_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_last_of_run |=> o_out_valid)
        else $error("gap inside a group");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind uudecode_char_stream uud_checker u_uud_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_in_char          (i_in_char),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_out_byte         (o_out_byte),
    .o_out_last_of_run  (o_out_last_of_run),
    .o_out_last_of_line (o_out_last_of_line)
);
`default_nettype wire

### dv/uudecode_char_stream_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uudecode_char_stream_tb
// Feeds uuencoded text into the decoder one character per item and checks
// every decoded byte and its run and line marks against a line decoder kept
// in the bench. Covers empty, skipped, marker and short lines, raw byte
// values, long lines with large counts, output back-pressure and random
// text, with random idle cycles on both channels.
// ---------------------------------------------------------------------------
module uudecode_char_stream_tb;
    import uud_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          RANDOM_ITEMS   = 100;
    localparam logic [39:0] BEGIN_TEXT     = "begin";
    localparam logic [23:0] END_TEXT       = "end";

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       line_end;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_char = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last_of_run;
    logic       o_out_last_of_line;

    t_decoded expected_bytes[$];
    int       fail_count = 0;
    int       stall_cycles = 0;
    int       chars_sent = 0;
    int       in_max_gap = 14;
    int       out_max_gap = 14;
    int       long_hold_cycles = 0;

    // line decoder state
    logic [6:0]  line_pos;
    logic [5:0]  line_len;
    logic [5:0]  line_bytes;
    logic [17:0] group_bits;
    logic [1:0]  group_fill;
    logic        begin_seen;
    logic        end_seen;
    logic        line_skipped;

    uudecode_char_stream uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_char          (i_in_char),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_out_last_of_run  (o_out_last_of_run),
        .o_out_last_of_line (o_out_last_of_line)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        return (c == CHAR_BACKTICK) ? 6'd0 : 6'(c - CHAR_SPACE);
    endfunction

    function automatic void clear_line_state();
        line_pos     = 7'd0;
        line_len     = 6'd0;
        line_bytes   = 6'd0;
        group_bits   = 18'd0;
        group_fill   = 2'd0;
        begin_seen   = 1'b0;
        end_seen     = 1'b0;
        line_skipped = 1'b0;
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        int          pos;
        int          remaining;
        int          nb;
        logic [5:0]  s;
        logic [23:0] word;
        t_decoded    item;
        if (c == CHAR_NEWLINE) begin
            clear_line_state();
            return;
        end
        pos = line_pos;
        if (line_pos != COLUMN_MAX) line_pos = line_pos + 7'd1;
        s = sextet_of(c);
        if (pos == 0) begin
            line_len     = s;
            line_bytes   = 6'd0;
            group_bits   = 18'd0;
            group_fill   = 2'd0;
            begin_seen   = (c == BEGIN_TEXT[39 -: 8]);
            end_seen     = (c == END_TEXT[23 -: 8]);
            line_skipped = (s == 6'd0);
            return;
        end
        if (line_skipped) return;
        if (pos <= 4) begin
            begin_seen = begin_seen && (c == BEGIN_TEXT[39 - 8 * pos -: 8]);
            if (pos == 4 && begin_seen) begin
                line_skipped = 1'b1;
                return;
            end
        end
        if (pos <= 2) begin
            end_seen = end_seen && (c == END_TEXT[23 - 8 * pos -: 8]);
            if (pos == 2 && end_seen) begin
                line_skipped = 1'b1;
                return;
            end
        end
        if (line_bytes >= line_len) return;
        if (group_fill != 2'd3) begin
            group_bits = {group_bits[11:0], s};
            group_fill = group_fill + 2'd1;
            return;
        end
        word       = {group_bits, s};
        group_bits = 18'd0;
        group_fill = 2'd0;
        remaining  = int'(line_len) - int'(line_bytes);
        nb         = (remaining < 3) ? remaining : 3;
        for (int k = 0; k < nb; k++) begin
            line_bytes    = line_bytes + 6'd1;
            item.data     = word[23 - 8 * k -: 8];
            item.run_end  = (k == nb - 1);
            item.line_end = (line_bytes == line_len);
            expected_bytes.push_back(item);
        end
    endfunction

    function automatic void check_byte();
        t_decoded want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected byte: got %0h", o_out_byte);
            fail_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (o_out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
            fail_count++;
        end
        if (o_out_last_of_run !== want.run_end) begin
            $error("last_of_run: expected %0b, got %0b", want.run_end, o_out_last_of_run);
            fail_count++;
        end
        if (o_out_last_of_line !== want.line_end) begin
            $error("last_of_line: expected %0b, got %0b", want.line_end,
                   o_out_last_of_line);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) decode_char(i_in_char);
            if (o_out_valid && i_out_ready) check_byte();
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin : byte_sink
        int pause;
        @(posedge i_rst_n);
        forever begin
            pause = $urandom_range(0, out_max_gap);
            if (long_hold_cycles > 0) begin
                pause = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (pause > 0) begin
                i_out_ready <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c);
        int pause;
        pause = $urandom_range(0, in_max_gap);
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] uu_char(input logic [5:0] s);
        logic [7:0] c;
        c = CHAR_SPACE + {2'b00, s};
        if (s == 6'd0 && $urandom_range(0, 1) == 1) begin
            c = CHAR_BACKTICK;
        end else if ($urandom_range(0, 7) == 0) begin
            c = c + 8'(64 * $urandom_range(1, 3));
            if (c == CHAR_NEWLINE) c = CHAR_SPACE + {2'b00, s};
        end
        return c;
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 254));
        if (c >= CHAR_NEWLINE) c = c + 8'd1;
        return c;
    endfunction

    // keep = 0 sends the whole line, otherwise only its first keep characters
    task automatic send_data_line(input int count, input int extra, input int keep);
        logic [7:0]  line[$];
        logic [23:0] word;
        line.push_back(uu_char(6'(count)));
        for (int g = 0; g < (count + 2) / 3; g++) begin
            word = 24'($urandom);
            for (int k = 0; k < 4; k++) line.push_back(uu_char(word[23 - 6 * k -: 6]));
        end
        repeat (extra) line.push_back(any_but_newline());
        if (keep > 0) begin
            while (line.size() > keep) void'(line.pop_back());
        end
        foreach (line[i]) send_char(line[i]);
        send_char(CHAR_NEWLINE);
    endtask

    task automatic send_marker_line();
        string heads[7] = '{"begin", "end", "beg", "bexin", "en", "enx", "endless"};
        send_text(heads[$urandom_range(0, 6)]);
        repeat ($urandom_range(0, 12)) send_char(uu_char(6'($urandom)));
        send_char(CHAR_NEWLINE);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20)) send_char(8'($urandom));
        send_char(CHAR_NEWLINE);
    endtask

    task automatic test_empty_and_skipped();
        send_text("\n");
        send_char(CHAR_BACKTICK);
        send_text("x\n");
        send_text("begin\n");
        send_text("end\n");
    endtask

    task automatic test_marker_prefix_and_raw_bytes();
        send_char("b");
        send_char(8'h00);
        send_char(8'h0d);
        send_char(8'hff);
        send_char("_");
        send_char(CHAR_NEWLINE);
    endtask

    task automatic test_full_and_short_groups();
        send_text("#____\n");
        send_text("#ab\n");
    endtask

    task automatic test_long_line();
        in_max_gap  = 0;
        out_max_gap = 0;
        send_data_line(63, 46, 0);
        in_max_gap  = 14;
        out_max_gap = 14;
    endtask

    task automatic test_output_backpressure();
        in_max_gap       = 0;
        long_hold_cycles = 300;
        send_data_line(45, 0, 0);
        wait_drained();
        in_max_gap = 14;
    endtask

    task automatic test_random_lines();
        int start;
        int pick;
        int count;
        start = chars_sent;
        while (chars_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                in_max_gap  = 0;
                out_max_gap = 0;
            end else begin
                in_max_gap  = 14;
                out_max_gap = 14;
            end
            pick  = $urandom_range(0, 99);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63)
                                                : $urandom_range(1, 12);
            if (pick < 60) begin
                send_data_line(count, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0,
                               0);
            end else if (pick < 72) begin
                send_data_line(count, 0, $urandom_range(2, 4 * ((count + 2) / 3)));
            end else if (pick < 82) begin
                send_marker_line();
            end else if (pick < 92) begin
                send_noise();
            end else if (pick[0]) begin
                send_text("\n");
            end else begin
                send_data_line(0, $urandom_range(0, 5), 0);
            end
        end
    endtask

    initial begin
        clear_line_state();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_skipped();
        test_marker_prefix_and_raw_bytes();
        test_full_and_short_groups();
        test_long_line();
        test_output_backpressure();
        test_random_lines();
        wait_drained();
        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
